@@ design/edd_pkg.sv @@
// ----------------------------------------------------------------------------
// edd_pkg
// Types, constants and helper functions shared by the error diffusion dither.
// ----------------------------------------------------------------------------
package edd_pkg;

	localparam int CHAN_W    = 8;
	localparam int ERR_W     = 3 * CHAN_W;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 9;
	localparam int KEPT_W    = 4;

	// diffusion weights, in sixteenths
	localparam logic [2:0] WT_UP_LEFT  = 3'd1;
	localparam logic [2:0] WT_UP       = 3'd5;
	localparam logic [2:0] WT_UP_RIGHT = 3'd3;
	localparam logic [2:0] WT_LEFT     = 3'd7;

	localparam logic [KEPT_W-1:0] KEPT_MAX = KEPT_W'(8);

	typedef logic [ERR_W-1:0] err_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH   = 2'd0,
		REG_IMAGE_HEIGHT  = 2'd1,
		REG_KEPT_BITS     = 2'd2,
		REG_DITHER_ENABLE = 2'd3
	} cfg_reg_t;

	// per-pixel tap selection and frame flags; taps and quantize already gated by dither enable
	typedef struct packed {
		logic use_ul;
		logic use_up;
		logic use_ur;
		logic use_left;
		logic quantize;
		logic frame_start;
		logic frame_end;
	} tap_sel_t;

	function automatic logic [CHAN_W-1:0] add_share(
		input logic [CHAN_W-1:0] v,
		input logic [CHAN_W-1:0] e,
		input logic [2:0]        wt
	);
		logic [10:0] prod;
		logic [8:0]  s;
		prod = 11'(e) * 11'(wt);
		s    = {1'b0, v} + 9'(prod >> 4);
		return s[8] ? {CHAN_W{1'b1}} : s[CHAN_W-1:0];
	endfunction

	function automatic logic [CHAN_W-1:0] keep_mask(input logic [KEPT_W-1:0] kept);
		logic [KEPT_W-1:0] k;
		k = (kept > KEPT_MAX) ? KEPT_MAX : kept;
		return CHAN_W'(16'hFF00 >> k);
	endfunction

endpackage

@@ design/edd_if.sv @@
// ----------------------------------------------------------------------------
// edd_if
// Valid/ready channel interfaces: input pixels, result pixels, config writes.
// ----------------------------------------------------------------------------
interface edd_pixel_if import edd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] in_red;
	logic [CHAN_W-1:0] in_green;
	logic [CHAN_W-1:0] in_blue;

	modport source (output valid, output in_red, output in_green, output in_blue,
		input ready);
	modport sink (input valid, input in_red, input in_green, input in_blue,
		output ready);
endinterface

interface edd_result_if import edd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] out_red;
	logic [CHAN_W-1:0] out_green;
	logic [CHAN_W-1:0] out_blue;
	logic              frame_end;

	modport source (output valid, output out_red, output out_green, output out_blue,
		output frame_end, input ready);
	modport sink (input valid, input out_red, input out_green, input out_blue,
		input frame_end, output ready);
endinterface

interface edd_cfg_if import edd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/edd_line_ram.sv @@
// ----------------------------------------------------------------------------
// edd_line_ram
// Line store of pixel errors: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module edd_line_ram import edd_pkg::*; #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  err_t          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output err_t          rdata_a,
	output err_t          rdata_b
);

	err_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

@@ design/edd_core.sv @@
// ----------------------------------------------------------------------------
// edd_core
// Per-channel error accumulation, clamping and quantization of one pixel.
// ----------------------------------------------------------------------------
module edd_core import edd_pkg::*; (
	input  tap_sel_t          sel,
	input  logic [CHAN_W-1:0] mask,
	input  err_t              pix,
	input  err_t              err_ul,
	input  err_t              err_up,
	input  err_t              err_ur,
	input  err_t              err_left,
	output err_t              pix_out,
	output err_t              err_out
);

	always_comb begin
		logic [CHAN_W-1:0] v;
		logic [CHAN_W-1:0] q;
		pix_out = '0;
		err_out = '0;
		for (int c = 0; c < 3; c++) begin
			v = pix[c*CHAN_W +: CHAN_W];
			if (sel.use_ul) begin
				v = add_share(v, err_ul[c*CHAN_W +: CHAN_W], WT_UP_LEFT);
			end
			if (sel.use_up) begin
				v = add_share(v, err_up[c*CHAN_W +: CHAN_W], WT_UP);
			end
			if (sel.use_ur) begin
				v = add_share(v, err_ur[c*CHAN_W +: CHAN_W], WT_UP_RIGHT);
			end
			if (sel.use_left) begin
				v = add_share(v, err_left[c*CHAN_W +: CHAN_W], WT_LEFT);
			end
			q = v & mask;
			if (sel.quantize) begin
				err_out[c*CHAN_W +: CHAN_W] = v - q;
				v = q;
			end
			pix_out[c*CHAN_W +: CHAN_W] = v;
		end
	end

endmodule

@@ design/error_diffusion_dither.sv @@
// ----------------------------------------------------------------------------
// error_diffusion_dither
// Floyd-Steinberg style dither of an RGB888 raster stream. One pixel is taken
// per clock unless result back-pressure stalls; it passes through the stage 1
// registers and the output register. Two line store reads and one write per
// pixel sustain one request per clock. The line store keeps the errors of the
// row above; it is never swept: a fill count marks which columns were written
// in the current frame and any other column reads as zero error, so there is
// no clearing pass after reset or at frame start.
// ----------------------------------------------------------------------------
module error_diffusion_dither import edd_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	edd_pixel_if.sink    pixel,
	edd_result_if.source result,
	edd_cfg_if.sink      cfg
);

	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int YW  = $clog2(MAX_HEIGHT);
	localparam int FW  = XW + 1;
	localparam int CWR = ((XW > YW) ? XW : YW) + 2;
	localparam int CW  = (CWR < 10) ? 10 : CWR;

	// configuration
	logic [CFG_DAT_W-1:0] width_q;
	logic [CFG_DAT_W-1:0] height_q;
	logic [KEPT_W-1:0]    kept_q;
	logic                 dither_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_DAT_W'(256);
			height_q <= CFG_DAT_W'(224);
			kept_q   <= KEPT_W'(5);
			dither_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_IMAGE_WIDTH:   width_q  <= cfg.data;
				REG_IMAGE_HEIGHT:  height_q <= cfg.data;
				REG_KEPT_BITS:     kept_q   <= cfg.data[KEPT_W-1:0];
				REG_DITHER_ENABLE: dither_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	logic [CW-1:0] w_eff, h_eff;

	always_comb begin
		if (CW'(width_q) < CW'(3)) begin
			w_eff = CW'(3);
		end else if (CW'(width_q) > CW'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(width_q);
		end
		if (CW'(height_q) < CW'(3)) begin
			h_eff = CW'(3);
		end else if (CW'(height_q) > CW'(MAX_HEIGHT)) begin
			h_eff = CW'(MAX_HEIGHT);
		end else begin
			h_eff = CW'(height_q);
		end
	end

	// pipeline control
	logic valid_s1;
	logic out_valid_q;
	logic adv_s1;
	logic accept;

	assign adv_s1      = valid_s1 && (!out_valid_q || result.ready);
	assign pixel.ready = !valid_s1 || adv_s1;
	assign accept      = pixel.valid && pixel.ready;

	// position and tap selection
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [CW-1:0] xe, ye;
	tap_sel_t      sel_s0;
	logic          row_ok, in_rows, mid_cols;

	assign xe = CW'(x_q);
	assign ye = CW'(y_q);

	always_comb begin
		row_ok   = (ye >= CW'(2)) && (ye + CW'(1) <= h_eff);
		in_rows  = (ye >= CW'(1)) && (ye + CW'(2) <= h_eff);
		mid_cols = (xe >= CW'(2)) && (xe + CW'(1) <= w_eff);
		sel_s0.use_ul      = dither_q && row_ok && mid_cols;
		sel_s0.use_up      = dither_q && row_ok && (xe >= CW'(1)) && (xe + CW'(2) <= w_eff);
		sel_s0.use_ur      = dither_q && row_ok && (xe + CW'(3) <= w_eff);
		sel_s0.use_left    = dither_q && in_rows && mid_cols;
		sel_s0.quantize    = dither_q && in_rows && (xe >= CW'(1))
			&& (xe + CW'(2) <= w_eff);
		sel_s0.frame_start = (x_q == '0) && (y_q == '0);
		sel_s0.frame_end   = (xe + CW'(1) >= w_eff) && (ye + CW'(1) >= h_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (accept) begin
			if (xe + CW'(1) >= w_eff) begin
				x_q <= '0;
				y_q <= (ye + CW'(1) >= h_eff) ? '0 : YW'(ye + CW'(1));
			end else begin
				x_q <= XW'(xe + CW'(1));
			end
		end
	end

	// stage 1 registers
	tap_sel_t      sel_s1;
	err_t          pix_s1;
	logic [XW-1:0] x_s1;
	logic          up_ok_s1, ur_ok_s1;

	// line store fill tracking
	logic [FW-1:0] fill_q, fill_next, fill_eff, x_f, xp1_f, xs1_f;
	logic          up_ok_s0, ur_ok_s0;

	always_comb begin
		xs1_f = FW'(x_s1) + FW'(1);
		if (sel_s1.frame_start) begin
			fill_next = FW'(1);
		end else if (xs1_f > fill_q) begin
			fill_next = xs1_f;
		end else begin
			fill_next = fill_q;
		end
		fill_eff = adv_s1 ? fill_next : fill_q;
		x_f      = FW'(x_q);
		xp1_f    = FW'(x_q) + FW'(1);
		up_ok_s0 = !sel_s0.frame_start && (x_f < fill_eff);
		ur_ok_s0 = !sel_s0.frame_start && (xp1_f < FW'(MAX_WIDTH)) && (xp1_f < fill_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (adv_s1) begin
			fill_q <= fill_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel.ready) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sel_s1   <= sel_s0;
			pix_s1   <= {pixel.in_blue, pixel.in_green, pixel.in_red};
			x_s1     <= x_q;
			up_ok_s1 <= up_ok_s0;
			ur_ok_s1 <= ur_ok_s0;
		end
	end

	// line store
	err_t rd_up, rd_ur, err_up, err_ur, err_own, pix_res;
	err_t held_q, left_q;

	edd_line_ram #(
		.DEPTH (MAX_WIDTH),
		.AW    (XW)
	) u_line_ram (
		.clk     (clk),
		.we      (adv_s1),
		.waddr   (x_s1),
		.wdata   (err_own),
		.re      (accept),
		.raddr_a (x_q),
		.raddr_b (XW'(xp1_f)),
		.rdata_a (rd_up),
		.rdata_b (rd_ur)
	);

	assign err_up = up_ok_s1 ? rd_up : '0;
	assign err_ur = ur_ok_s1 ? rd_ur : '0;

	edd_core u_core (
		.sel      (sel_s1),
		.mask     (keep_mask(kept_q)),
		.pix      (pix_s1),
		.err_ul   (held_q),
		.err_up   (err_up),
		.err_ur   (err_ur),
		.err_left (left_q),
		.pix_out  (pix_res),
		.err_out  (err_own)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			left_q <= '0;
		end else if (adv_s1) begin
			held_q <= err_up;
			left_q <= err_own;
		end
	end

	// output register
	err_t pix_q;
	logic frame_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			pix_q       <= pix_res;
			frame_end_q <= sel_s1.frame_end;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.out_red   = pix_q[CHAN_W-1:0];
	assign result.out_green = pix_q[2*CHAN_W-1:CHAN_W];
	assign result.out_blue  = pix_q[3*CHAN_W-1:2*CHAN_W];
	assign result.frame_end = frame_end_q;

endmodule
